/* hdl/tme_pkg.sv */
// tme_pkg: types and constants shared by the tape machine execute block.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package tme_pkg;

    localparam int TAPE_DEPTH_DEF = 256;
    localparam int Q_DEPTH        = 2;
    localparam int QPTR_W         = $clog2(Q_DEPTH);
    localparam int QCNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PROG_LEN_RST = 8'd255;

    // program byte encodings
    localparam logic [7:0] OPC_HALT  = 8'h00;
    localparam logic [7:0] OPC_INC   = 8'h01;
    localparam logic [7:0] OPC_DEC   = 8'h02;
    localparam logic [7:0] OPC_RIGHT = 8'h03;
    localparam logic [7:0] OPC_LEFT  = 8'h04;
    localparam logic [7:0] OPC_PRINT = 8'h05;
    localparam logic [7:0] OPC_READ  = 8'h06;
    localparam logic [7:0] OPC_JZ    = 8'h07;
    localparam logic [7:0] OPC_JNZ   = 8'h08;

    typedef enum logic [3:0] {
        OP_HALT,
        OP_INC,
        OP_DEC,
        OP_RIGHT,
        OP_LEFT,
        OP_PRINT,
        OP_READ,
        OP_JZ,
        OP_JNZ,
        OP_BAD
    } t_op_class;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_HALT    = 3'd1,
        ST_END     = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_JUMP    = 3'd5,
        ST_UNKNOWN = 3'd6
    } t_status;

    typedef struct packed {
        t_op_class  op;
        logic [7:0] operand;
        logic [7:0] read_char;
    } t_dec;

    typedef struct packed {
        logic push;
        t_dec item;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_dec item;
    } t_q_rd;

endpackage

`default_nettype wire

/* hdl/tme_front.sv */
// tme_front: accepts input items and classifies the opcode byte.
// Depends on tme_pkg; feeds tme_queue.
`default_nettype none

module tme_front (
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_opcode,
    input  wire logic [7:0]    i_operand,
    input  wire logic [7:0]    i_read_char,
    input  wire logic          i_q_full,
    output tme_pkg::t_q_wr     o_q_wr
);
    import tme_pkg::*;

    t_op_class w_op;

    always_comb begin
        case (i_opcode)
            OPC_HALT:  w_op = OP_HALT;
            OPC_INC:   w_op = OP_INC;
            OPC_DEC:   w_op = OP_DEC;
            OPC_RIGHT: w_op = OP_RIGHT;
            OPC_LEFT:  w_op = OP_LEFT;
            OPC_PRINT: w_op = OP_PRINT;
            OPC_READ:  w_op = OP_READ;
            OPC_JZ:    w_op = OP_JZ;
            OPC_JNZ:   w_op = OP_JNZ;
            default:   w_op = OP_BAD;
        endcase
    end

    assign o_in_stall             = i_q_full;
    assign o_q_wr.push            = i_in_valid && !i_q_full;
    assign o_q_wr.item.op         = w_op;
    assign o_q_wr.item.operand    = i_operand;
    assign o_q_wr.item.read_char  = i_read_char;

endmodule

`default_nettype wire

/* hdl/tme_queue.sv */
// tme_queue: short queue of classified items between front and back.
// Depends on tme_pkg.
`default_nettype none

module tme_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tme_pkg::t_q_wr i_q_wr,
    input  wire logic          i_pop,
    output tme_pkg::t_q_rd     o_q_rd,
    output logic               o_full
);
    import tme_pkg::*;

    t_dec              r_slot [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_q_wr.push) begin
            n_wptr = (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({i_q_wr.push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_slot[r_wptr] <= i_q_wr.item;
        end
    end

    assign o_full       = (r_count == QCNT_W'(Q_DEPTH));
    assign o_q_rd.valid = (r_count != '0);
    assign o_q_rd.item  = r_slot[r_rptr];

endmodule

`default_nettype wire

/* hdl/tme_back.sv */
// tme_back: executes queued items against the tape, pc and stop status,
// and holds the result register. Depends on tme_pkg.
`default_nettype none

module tme_back #(
    parameter int TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [7:0]    i_cfg_wr_data,
    input  wire tme_pkg::t_q_rd i_q_rd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_next_pc,
    output logic               o_print_valid,
    output logic [7:0]         o_print_char,
    output logic [2:0]         o_status
);
    import tme_pkg::*;

    localparam int ADDR_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TAPE_DEPTH - 1);

    logic [7:0]        r_tape [TAPE_DEPTH];
    logic [TAPE_DEPTH-1:0] r_cell_vld;

    logic [7:0]        r_prog_len;
    logic [7:0]        r_pc, n_pc;
    logic [ADDR_W-1:0] r_dp, n_dp;
    t_status           r_stop, n_stop;

    // registered read of the cell under the next data pointer
    logic [7:0]        r_mem_q;
    logic              r_vld_q;
    logic              r_fwd;
    logic [7:0]        r_fwd_data;

    logic              r_out_valid;
    logic [7:0]        r_out_pc;
    logic              r_out_pv;
    logic [7:0]        r_out_pch;
    t_status           r_out_st;

    logic              w_exec;
    logic [7:0]        w_cell;
    logic              w_wr;
    logic [7:0]        w_wr_data;
    logic              w_pv;
    logic [7:0]        w_pch;
    logic              w_take;
    logic [8:0]        w_pc_inc;

    assign o_pop   = !r_out_valid || !i_out_stall;
    assign w_exec  = o_pop && i_q_rd.valid;
    assign w_cell  = r_fwd ? r_fwd_data : (r_vld_q ? r_mem_q : 8'd0);
    assign w_pc_inc = {1'b0, r_pc} + 9'd1;

    always_comb begin
        n_pc      = r_pc;
        n_dp      = r_dp;
        n_stop    = r_stop;
        w_wr      = 1'b0;
        w_wr_data = w_cell;
        w_pv      = 1'b0;
        w_pch     = 8'd0;
        w_take    = 1'b0;
        if (w_exec && (r_stop == ST_RUN)) begin
            if (r_pc >= r_prog_len) begin
                n_stop = ST_END;
            end else begin
                case (i_q_rd.item.op)
                    OP_HALT: begin
                        n_stop = ST_HALT;
                    end
                    OP_INC: begin
                        w_wr      = 1'b1;
                        w_wr_data = w_cell + 8'd1;
                        n_pc      = r_pc + 8'd1;
                    end
                    OP_DEC: begin
                        w_wr      = 1'b1;
                        w_wr_data = w_cell - 8'd1;
                        n_pc      = r_pc + 8'd1;
                    end
                    OP_RIGHT: begin
                        if (r_dp == LAST_CELL) begin
                            n_stop = ST_FULL;
                        end else begin
                            n_dp = r_dp + 1'b1;
                            n_pc = r_pc + 8'd1;
                        end
                    end
                    OP_LEFT: begin
                        if (r_dp == '0) begin
                            n_stop = ST_EMPTY;
                        end else begin
                            n_dp = r_dp - 1'b1;
                            n_pc = r_pc + 8'd1;
                        end
                    end
                    OP_PRINT: begin
                        w_pv  = 1'b1;
                        w_pch = w_cell;
                        n_pc  = r_pc + 8'd1;
                    end
                    OP_READ: begin
                        w_wr      = 1'b1;
                        w_wr_data = i_q_rd.item.read_char;
                        n_pc      = r_pc + 8'd1;
                    end
                    OP_JZ, OP_JNZ: begin
                        w_take = (i_q_rd.item.op == OP_JZ) ? (w_cell == 8'd0)
                                                           : (w_cell != 8'd0);
                        if (w_take) begin
                            if (w_pc_inc >= {1'b0, r_prog_len}) begin
                                n_stop = ST_JUMP;
                            end else begin
                                n_pc = i_q_rd.item.operand;
                            end
                        end else begin
                            n_pc = r_pc + 8'd2;
                        end
                    end
                    default: begin
                        n_stop = ST_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len  <= PROG_LEN_RST;
            r_pc        <= 8'd0;
            r_dp        <= '0;
            r_stop      <= ST_RUN;
            r_cell_vld  <= '0;
            r_vld_q     <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prog_len <= i_cfg_wr_data;
            end
            r_pc   <= n_pc;
            r_dp   <= n_dp;
            r_stop <= n_stop;
            if (w_wr) begin
                r_cell_vld[r_dp] <= 1'b1;
            end
            r_vld_q <= r_cell_vld[n_dp];
            // bypass a write that lands on the cell being read
            r_fwd   <= w_wr && (r_dp == n_dp);
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_tape[r_dp] <= w_wr_data;
        end
        r_mem_q    <= r_tape[n_dp];
        r_fwd_data <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_pc  <= n_pc;
            r_out_pv  <= w_pv;
            r_out_pch <= w_pch;
            r_out_st  <= n_stop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_print_valid = r_out_pv;
    assign o_print_char  = r_out_pch;
    assign o_status      = r_out_st;

endmodule

`default_nettype wire

/* hdl/tape_machine_execute_top.sv */
// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_stall   i_opcode, i_operand, i_read_char
// out       out  o_out_valid / i_out_stall o_next_pc, o_print_valid, o_print_char, o_status
// cfg       in   i_cfg_wr_en               i_cfg_wr_data (program_length)
//
// One item per cycle sustained while the output is not stalled; an accepted item
// is decoded into a two-entry queue, then executed into the result register.
// The data pointer's cell is read ahead from the tape memory into a register, with
// a bypass of the write just made, so consecutive items on one cell do not wait.
// Reset is synchronous; the tape reads as zero through per-cell valid bits.
// An output stall holds the result and backs up through the queue to o_in_stall.
// Depends on tme_pkg, tme_front, tme_queue and tme_back.
`default_nettype none

module tape_machine_execute_top #(
    parameter int TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_opcode,
    input  wire logic [7:0] i_operand,
    input  wire logic [7:0] i_read_char,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_next_pc,
    output logic            o_print_valid,
    output logic [7:0]      o_print_char,
    output logic [2:0]      o_status
);
    import tme_pkg::*;

    t_q_wr w_q_wr;
    t_q_rd w_q_rd;
    logic  w_q_full;
    logic  w_pop;

    tme_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_operand   (i_operand),
        .i_read_char (i_read_char),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr)
    );

    tme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (w_q_wr),
        .i_pop   (w_pop),
        .o_q_rd  (w_q_rd),
        .o_full  (w_q_full)
    );

    tme_back #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_rd        (w_q_rd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_next_pc     (o_next_pc),
        .o_print_valid (o_print_valid),
        .o_print_char  (o_print_char),
        .o_status      (o_status)
    );

`ifndef ASSERT_OFF
    a_print_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_print_valid) |-> (o_status == ST_RUN))
        else $error("print reported with a stop status");

    a_quiet_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_print_valid) |-> (o_print_char == 8'd0))
        else $error("print_char nonzero without print");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_sticky_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && (o_status != ST_RUN))
        |=> (!o_out_valid || (o_status == $past(o_status))))
        else $error("stop status changed before reset");
`endif

endmodule

`default_nettype wire

/* test/tme_checker.sv */
// tme_checker: watches the in, out and config channels of tape_machine_execute_top,
// runs every accepted item on its own tape, pointers and length, and counts mismatches.
// Depends on tme_pkg.
`timescale 1ns / 1ps

module tme_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_read_char,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_next_pc,
    input  logic       i_print_valid,
    input  logic [7:0] i_print_char,
    input  logic [2:0] i_status,
    output int         o_errors,
    output int         o_pending,
    output logic [7:0] o_pc,
    output logic [7:0] o_dp,
    output logic [7:0] o_cell
);
    import tme_pkg::*;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       print_valid;
        logic [7:0] print_char;
        t_status    status;
    } t_step_result;

    logic [7:0]   tape_mem [0:255];
    logic [7:0]   data_ptr;
    logic [7:0]   prog_ctr;
    logic [7:0]   prog_len;
    t_status      stop_state;
    t_step_result step_results_q[$];
    t_step_result got;
    t_step_result want;
    int           n_results;

    initial o_errors = 0;

    task automatic flag(input string msg);
        o_errors++;
        if (o_errors <= 10) $display("%s", msg);
    endtask

    // Execute one instruction on the local machine state and return its result.
    function automatic t_step_result exec_instr(input logic [7:0] op, input logic [7:0] target,
                                                input logic [7:0] rd_char);
        t_step_result res;
        logic         taken;
        res.print_valid = 1'b0;
        res.print_char  = 8'h00;
        if (stop_state == ST_RUN) begin
            if (prog_ctr >= prog_len) begin
                stop_state = ST_END;
            end else begin
                case (op)
                    OPC_HALT: stop_state = ST_HALT;
                    OPC_INC: begin
                        tape_mem[data_ptr] = tape_mem[data_ptr] + 8'd1;
                        prog_ctr = prog_ctr + 8'd1;
                    end
                    OPC_DEC: begin
                        tape_mem[data_ptr] = tape_mem[data_ptr] - 8'd1;
                        prog_ctr = prog_ctr + 8'd1;
                    end
                    OPC_RIGHT: begin
                        if (data_ptr == 8'd255) begin
                            stop_state = ST_FULL;
                        end else begin
                            data_ptr = data_ptr + 8'd1;
                            prog_ctr = prog_ctr + 8'd1;
                        end
                    end
                    OPC_LEFT: begin
                        if (data_ptr == 8'd0) begin
                            stop_state = ST_EMPTY;
                        end else begin
                            data_ptr = data_ptr - 8'd1;
                            prog_ctr = prog_ctr + 8'd1;
                        end
                    end
                    OPC_PRINT: begin
                        res.print_valid = 1'b1;
                        res.print_char  = tape_mem[data_ptr];
                        prog_ctr = prog_ctr + 8'd1;
                    end
                    OPC_READ: begin
                        tape_mem[data_ptr] = rd_char;
                        prog_ctr = prog_ctr + 8'd1;
                    end
                    OPC_JZ, OPC_JNZ: begin
                        taken = ((op == OPC_JZ) == (tape_mem[data_ptr] == 8'd0));
                        if (!taken) begin
                            prog_ctr = prog_ctr + 8'd2;
                        end else if ({1'b0, prog_ctr} + 9'd1 >= {1'b0, prog_len}) begin
                            stop_state = ST_JUMP;
                        end else begin
                            prog_ctr = target;
                        end
                    end
                    default: stop_state = ST_UNKNOWN;
                endcase
            end
        end
        res.next_pc = prog_ctr;
        res.status  = stop_state;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) tape_mem[i] = 8'h00;
            data_ptr   = 8'd0;
            prog_ctr   = 8'd0;
            prog_len   = PROG_LEN_RST;
            stop_state = ST_RUN;
            n_results  = 0;
            step_results_q.delete();
        end else begin
            // compare before pushing: an item accepted now cannot be the result seen now
            if (i_out_valid && !i_out_stall) begin
                got.next_pc     = i_next_pc;
                got.print_valid = i_print_valid;
                got.print_char  = i_print_char;
                got.status      = t_status'(i_status);
                if (step_results_q.size() == 0) begin
                    flag($sformatf({"tme_checker: result %0d with nothing expected: ",
                                    "pc=%0d pv=%b ch=%0d st=%0d"},
                                   n_results, got.next_pc, got.print_valid,
                                   got.print_char, got.status));
                end else begin
                    want = step_results_q.pop_front();
                    if (got !== want) begin
                        flag($sformatf({"tme_checker: result %0d: expected ",
                                        "pc=%0d pv=%b ch=%0d st=%0d, got ",
                                        "pc=%0d pv=%b ch=%0d st=%0d"},
                                       n_results, want.next_pc, want.print_valid,
                                       want.print_char, want.status, got.next_pc,
                                       got.print_valid, got.print_char, got.status));
                    end
                end
                n_results++;
            end
            if (i_in_valid && !i_in_stall) begin
                step_results_q.push_back(exec_instr(i_opcode, i_operand, i_read_char));
            end
            if (i_cfg_wr_en) prog_len = i_cfg_wr_data;
        end
        o_pending = step_results_q.size();
        o_pc      = prog_ctr;
        o_dp      = data_ptr;
        o_cell    = tape_mem[data_ptr];
    end

endmodule

/* test/tb.sv */
// tb: drives tape_machine_execute_top with programs that keep the machine running,
// then forces one stop, and gives the verdict from the tme_checker error count.
// Depends on tme_pkg, tape_machine_execute_top and tme_checker.
`timescale 1ns / 1ps

module tb;
    import tme_pkg::*;

    localparam int IDLE_PCT    = 37;
    localparam int HOLD_STAGE  = 1;
    localparam int CALM_STAGE  = 3;
    localparam int LAST_STAGE  = 7;
    localparam int HOLD_CYCLES = 60;
    localparam int STAGE_ITEMS = 90;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] rc;
    } t_instr;

    typedef enum {
        END_BY_HALT,
        END_BY_LENGTH,
        END_BY_FULL,
        END_BY_EMPTY,
        END_BY_JUMP,
        END_BY_OPCODE
    } t_ending;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] read_char;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] next_pc;
    logic       print_valid;
    logic [7:0] print_char;
    logic [2:0] status;

    int         errors;
    int         pending;
    logic [7:0] pc_now;
    logic [7:0] dp_now;
    logic [7:0] cell_now;
    logic [7:0] prog_len;
    int         stage;

    tape_machine_execute_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_operand    (operand),
        .i_read_char  (read_char),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_next_pc    (next_pc),
        .o_print_valid(print_valid),
        .o_print_char (print_char),
        .o_status     (status)
    );

    tme_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_operand    (operand),
        .i_read_char  (read_char),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_next_pc    (next_pc),
        .i_print_valid(print_valid),
        .i_print_char (print_char),
        .i_status     (status),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_pc         (pc_now),
        .o_dp         (dp_now),
        .o_cell       (cell_now)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // A pc is safe when the next step still runs and some instruction there keeps
    // it running: at most length - 2, or 254 under length 255 (wraps by a jump not taken).
    function automatic bit safe_pc(input int pc_next, input int len_val);
        int p;
        p = pc_next % 256;
        return (p <= len_val - 2) || (p == 254 && len_val == 255);
    endfunction

    function automatic t_instr jump(input bit taken, input logic [7:0] cur_cell,
                                    input logic [7:0] target);
        t_instr ins;
        ins.op  = ((cur_cell == 8'd0) == taken) ? OPC_JZ : OPC_JNZ;
        ins.arg = target;
        ins.rc  = 8'($urandom_range(255));
        return ins;
    endfunction

    // Pick a random instruction that keeps the machine running.
    function automatic t_instr next_instr(input logic [7:0] pc, input logic [7:0] dp,
                                          input logic [7:0] cur_cell,
                                          input logic [7:0] len_val);
        t_instr ins;
        int     r;
        bit     legal;
        do begin
            r       = $urandom_range(99);
            legal   = 1'b1;
            ins.arg = 8'($urandom_range(255));
            ins.rc  = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(255));
            if (r < 12) begin
                ins.op = OPC_INC;
            end else if (r < 24) begin
                ins.op = OPC_DEC;
            end else if (r < 34) begin
                ins.op = OPC_RIGHT;
                legal  = (dp != 8'd255);
            end else if (r < 44) begin
                ins.op = OPC_LEFT;
                legal  = (dp != 8'd0);
            end else if (r < 56) begin
                ins.op = OPC_PRINT;
            end else if (r < 68) begin
                ins.op = OPC_READ;
            end else if (r < 88) begin
                legal = (int'(pc) + 1 < int'(len_val));
                if (legal) ins = jump(1'b1, cur_cell,
                                      8'($urandom_range(int'(len_val) - 2)));
            end else begin
                ins   = jump(1'b0, cur_cell, 8'($urandom_range(255)));
                legal = safe_pc(int'(pc) + 2, int'(len_val));
            end
            if (r < 68) legal = legal && safe_pc(int'(pc) + 1, int'(len_val));
        end while (!legal);
        return ins;
    endfunction

    task automatic offer(input logic [7:0] op, input logic [7:0] arg, input logic [7:0] rc);
        while (stage != CALM_STAGE && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        operand   <= arg;
        read_char <= rc;
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_length(input logic [7:0] len_val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len_val;
        prog_len     = len_val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : receiver
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            // hold once for a long stretch so the queue fills and the input stalls
            if (stage == HOLD_STAGE && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= (stage != CALM_STAGE) && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin : stimulus
        t_instr     ins;
        t_ending    ending;
        int         steps;
        logic [7:0] new_len;
        logic [7:0] walk_op;
        logic [7:0] walk_end;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        in_valid    = 1'b0;
        opcode      = 8'h00;
        operand     = 8'h00;
        read_char   = 8'h00;
        stage       = 0;
        prog_len    = PROG_LEN_RST;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed program, reset length; pc runs 0..17 with skips, 253, 254, 0..2, 254, 0
        offer(OPC_PRINT, 8'h00, 8'h00);
        offer(OPC_DEC,   8'hFF, 8'hFF);
        offer(OPC_PRINT, 8'h55, 8'hAA);
        offer(OPC_INC,   8'hAA, 8'h55);
        offer(OPC_READ,  8'h00, 8'hFF);
        offer(OPC_JZ,    8'hFF, 8'h00);
        offer(OPC_JNZ,   8'd9,  8'h00);
        offer(OPC_READ,  8'hFF, 8'h00);
        offer(OPC_JNZ,   8'hAA, 8'hFF);
        offer(OPC_JZ,    8'd14, 8'h00);
        offer(OPC_RIGHT, 8'h0F, 8'hF0);
        offer(OPC_READ,  8'h00, 8'h80);
        offer(OPC_LEFT,  8'hF0, 8'h0F);
        offer(OPC_JZ,    8'd253, 8'h00);
        offer(OPC_INC,   8'h00, 8'h00);
        offer(OPC_JZ,    8'h00, 8'h00);
        offer(OPC_RIGHT, 8'h00, 8'h00);
        offer(OPC_PRINT, 8'h00, 8'h00);
        offer(OPC_JNZ,   8'd254, 8'h00);
        offer(OPC_JZ,    8'hFF, 8'hFF);
        drain();

        for (int s = 1; s <= LAST_STAGE; s++) begin
            stage <= s;
            case (s)
                1:       new_len = 8'd255;
                2:       new_len = 8'd2;
                4:       new_len = 8'd3;
                5:       new_len = 8'd254;
                7:       new_len = 8'($urandom_range(40, 4));
                default: new_len = 8'($urandom_range(254, 3));
            endcase
            set_length(new_len);
            repeat (STAGE_ITEMS) begin
                ins = next_instr(pc_now, dp_now, cell_now, prog_len);
                offer(ins.op, ins.arg, ins.rc);
            end
            // return pc to 0 so any new length is safe
            if (pc_now == 8'd254) ins = jump(1'b0, cell_now, 8'($urandom_range(255)));
            else ins = jump(1'b1, cell_now, 8'h00);
            offer(ins.op, ins.arg, ins.rc);
            drain();
        end

        // one stop per run, the kind left to the seed
        stage <= LAST_STAGE + 1;
        ending = t_ending'($urandom_range(END_BY_OPCODE));
        case (ending)
            END_BY_HALT: offer(OPC_HALT, 8'($urandom_range(255)), 8'($urandom_range(255)));
            END_BY_LENGTH: begin
                steps = $urandom_range(8, 1);
                set_length(8'(steps));
                repeat (steps + 1) offer(OPC_PRINT, 8'($urandom_range(255)),
                                         8'($urandom_range(255)));
            end
            END_BY_FULL, END_BY_EMPTY: begin
                walk_op  = (ending == END_BY_FULL) ? OPC_RIGHT : OPC_LEFT;
                walk_end = (ending == END_BY_FULL) ? 8'd255 : 8'd0;
                set_length(8'd255);
                while (dp_now != walk_end) begin
                    if (pc_now == 8'd253) begin
                        ins = jump(1'b1, cell_now, 8'h00);
                        offer(ins.op, ins.arg, ins.rc);
                    end else begin
                        offer(walk_op, 8'($urandom_range(255)), 8'($urandom_range(255)));
                    end
                end
                offer(walk_op, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            END_BY_JUMP: begin
                set_length(8'd1);
                ins = jump(1'b1, cell_now, 8'($urandom_range(255)));
                offer(ins.op, ins.arg, ins.rc);
            end
            default: offer(8'($urandom_range(255, OPC_JNZ + 1)), 8'($urandom_range(255)),
                           8'($urandom_range(255)));
        endcase
        drain();

        // stopped: every item is ignored, any byte goes
        set_length(8'h00);
        repeat (12) offer(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        drain();
        set_length(8'($urandom_range(255)));
        repeat (12) offer(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        drain();
        repeat (20) @(negedge clk);

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* tape_machine_execute_top.f */
hdl/tme_pkg.sv
hdl/tme_front.sv
hdl/tme_queue.sv
hdl/tme_back.sv
hdl/tape_machine_execute_top.sv
test/tme_checker.sv
test/tb.sv
